>>> design/cdc_pkg.sv
// Package for the calendar date counter: item types, request codes, month lengths.
`default_nettype none
package cdc_pkg;

	localparam int unsigned YEAR_W  = 16;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned REQ_W   = 3;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_LOAD    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INC     = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DEC     = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ADD     = 3'd3;
	localparam logic [REQ_W-1:0] REQ_COMPARE = 3'd4;

	localparam logic [YEAR_W-1:0]  YEAR_MAX  = 16'd65535;
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;

	// year / 100 by reciprocal: floor(y * 83887 / 2^23) is exact for 16-bit y
	localparam int unsigned         DIV100_SHIFT = 23;
	localparam logic [16:0]         DIV100_MUL   = 17'd83887;
	localparam int unsigned         Q100_W       = 10;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [YEAR_W-1:0]  in_year;
		logic [MONTH_W-1:0] in_month;
		logic [DAY_W-1:0]   in_day;
		logic [COUNT_W-1:0] day_count;
	} cdc_req_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  out_year;
		logic [MONTH_W-1:0] out_month;
		logic [DAY_W-1:0]   out_day;
		logic               is_later;
		logic               is_equal;
		logic               bad_load;
		logic               year_overflow;
	} cdc_res_t;

	typedef struct packed {
		logic later;
		logic equal;
		logic bad;
		logic ovf;
	} cdc_flags_t;

	// Days in a month; months outside 1..12 give 0
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

endpackage
`default_nettype wire

>>> design/cdc_chan_if.sv
// Valid/ready channel interface carrying one item of a given payload type.
`default_nettype none
interface cdc_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/calendar_date_counter.sv
// Gregorian date counter: load, step, add days and compare under a small sequencer.
//
// The block holds a date (reset 0001-01-01) and takes one request item at a time on req;
// each request yields exactly one result item on res with the stored date and flags.
// req.ready is high only while the sequencer is idle. Compare, refused loads, unknown
// codes and simple decrements go straight to the hold state; a load first runs the
// leap-year check of the new year (a reciprocal multiply for year/100, then the
// remainder test). Increment and add days run through one shared subtract-and-compare
// step that crosses one month per cycle, except that each year boundary crossed
// first runs the leap check of the new year. Decrement across a year boundary runs
// the leap check of the year before. The result register frees the sequencer to
// take the next request while a result waits.
`default_nettype none
module calendar_date_counter (
	input  wire logic clk,
	input  wire logic arst_n,
	cdc_chan_if.sink   req,
	cdc_chan_if.source res
);
	import cdc_pkg::*;

	// Sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_LEAP_MUL = 3'd1;
	localparam logic [2:0] S_LEAP_FIN = 3'd2;
	localparam logic [2:0] S_LOAD_FIN = 3'd3;
	localparam logic [2:0] S_ADD_STEP = 3'd4;
	localparam logic [2:0] S_COMMIT   = 3'd5;
	localparam logic [2:0] S_HOLD     = 3'd6;

	localparam int unsigned WD_W = COUNT_W + 1;

	// Flag sets written on acceptance
	localparam cdc_flags_t FLAGS_NONE = '{later: 1'b0, equal: 1'b0, bad: 1'b0, ovf: 1'b0};
	localparam cdc_flags_t FLAGS_BAD  = '{later: 1'b0, equal: 1'b0, bad: 1'b1, ovf: 1'b0};
	localparam cdc_flags_t FLAGS_OVF  = '{later: 1'b0, equal: 1'b0, bad: 1'b0, ovf: 1'b1};

	logic [2:0]         state_q, ret_q;
	logic [YEAR_W-1:0]  cur_year_q, wy_q;
	logic [MONTH_W-1:0] cur_month_q, wm_q;
	logic [DAY_W-1:0]   cur_day_q;
	logic               cur_leap_q, wleap_q;
	logic [WD_W-1:0]    wd_q;
	logic [Q100_W-1:0]  q100_q;
	cdc_flags_t         flags_q;
	cdc_res_t           out_q;
	logic               out_valid_q;

	cdc_req_t           rq;
	logic               accept;
	logic               out_free;
	logic               load_bad;
	logic [DAY_W-1:0]   cur_len_prev;
	logic [DAY_W-1:0]   wlen;
	logic [WD_W-1:0]    wlen_x;
	logic [16+17-1:0]   div_prod;
	logic [YEAR_W-1:0]  q100_x100;
	logic               leap_calc;
	logic [DAY_W-1:0]   load_day;
	logic               cmp_later;
	logic               cmp_equal;

	assign rq        = req.data;
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	assign load_bad = (rq.in_month < MONTH_JAN) || (rq.in_month > MONTH_DEC)
		|| (rq.in_year == '0);
	assign cur_len_prev = month_len(cur_month_q - MONTH_JAN, cur_leap_q);

	// Compare by year, then month, then day
	assign cmp_later = {cur_year_q, cur_month_q, cur_day_q}
		> {rq.in_year, rq.in_month, rq.in_day};
	assign cmp_equal = {cur_year_q, cur_month_q, cur_day_q}
		== {rq.in_year, rq.in_month, rq.in_day};

	// Shared step unit: month length of the working month against the day count
	assign wlen   = month_len(wm_q, wleap_q);
	assign wlen_x = {{(WD_W-DAY_W){1'b0}}, wlen};

	// Leap check: year/100 by reciprocal, then remainder and multiple-of-400 test
	assign div_prod  = wy_q * DIV100_MUL;
	assign q100_x100 = YEAR_W'({6'd0, q100_q} * 16'd100);
	assign leap_calc = (wy_q[1:0] == 2'b00) && ((wy_q != q100_x100) || (q100_q[1:0] == 2'b00));

	// Load day clamp
	assign load_day = ((wd_q[DAY_W-1:0] == '0) || (wd_q > wlen_x)) ? wlen : wd_q[DAY_W-1:0];

	// Sequencer and date state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			cur_year_q  <= 16'd1;
			cur_month_q <= MONTH_JAN;
			cur_day_q   <= 5'd1;
			cur_leap_q  <= 1'b0;
			flags_q     <= '0;
			wy_q        <= 16'd1;
			wm_q        <= MONTH_JAN;
			wd_q        <= '0;
			wleap_q     <= 1'b0;
			q100_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (rq.req_type)
							REQ_LOAD: begin
								if (load_bad) begin
									flags_q <= FLAGS_BAD;
									state_q <= S_HOLD;
								end else begin
									flags_q <= FLAGS_NONE;
									wy_q    <= rq.in_year;
									wm_q    <= rq.in_month;
									wd_q    <= {{(WD_W-DAY_W){1'b0}}, rq.in_day};
									ret_q   <= S_LOAD_FIN;
									state_q <= S_LEAP_MUL;
								end
							end
							REQ_INC: begin
								flags_q <= FLAGS_NONE;
								wy_q    <= cur_year_q;
								wm_q    <= cur_month_q;
								wleap_q <= cur_leap_q;
								wd_q    <= WD_W'(cur_day_q) + WD_W'(1);
								state_q <= S_ADD_STEP;
							end
							REQ_ADD: begin
								flags_q <= FLAGS_NONE;
								wy_q    <= cur_year_q;
								wm_q    <= cur_month_q;
								wleap_q <= cur_leap_q;
								wd_q    <= WD_W'(cur_day_q) + WD_W'(rq.day_count);
								state_q <= S_ADD_STEP;
							end
							REQ_DEC: begin
								if (cur_day_q > 5'd1) begin
									flags_q   <= FLAGS_NONE;
									cur_day_q <= cur_day_q - 5'd1;
									state_q   <= S_HOLD;
								end else if (cur_month_q > MONTH_JAN) begin
									flags_q     <= FLAGS_NONE;
									cur_month_q <= cur_month_q - MONTH_JAN;
									cur_day_q   <= cur_len_prev;
									state_q     <= S_HOLD;
								end else if (cur_year_q > 16'd1) begin
									flags_q <= FLAGS_NONE;
									wy_q    <= cur_year_q - 16'd1;
									wm_q    <= MONTH_DEC;
									wd_q    <= {{(WD_W-DAY_W){1'b0}}, DAY_LAST_DEC};
									ret_q   <= S_COMMIT;
									state_q <= S_LEAP_MUL;
								end else begin
									flags_q <= FLAGS_OVF;
									state_q <= S_HOLD;
								end
							end
							REQ_COMPARE: begin
								flags_q <= '{later: cmp_later, equal: cmp_equal,
									bad: 1'b0, ovf: 1'b0};
								state_q <= S_HOLD;
							end
							default: begin
								// unknown code: date untouched, no flags
								flags_q <= FLAGS_NONE;
								state_q <= S_HOLD;
							end
						endcase
					end
				end
				S_LEAP_MUL: begin
					q100_q  <= div_prod[DIV100_SHIFT +: Q100_W];
					state_q <= S_LEAP_FIN;
				end
				S_LEAP_FIN: begin
					wleap_q <= leap_calc;
					state_q <= ret_q;
				end
				S_LOAD_FIN: begin
					cur_year_q  <= wy_q;
					cur_month_q <= wm_q;
					cur_day_q   <= load_day;
					cur_leap_q  <= wleap_q;
					state_q     <= S_HOLD;
				end
				S_ADD_STEP: begin
					if (wd_q > wlen_x) begin
						wd_q <= wd_q - wlen_x;
						if (wm_q == MONTH_DEC) begin
							if (wy_q == YEAR_MAX) begin
								flags_q.ovf <= 1'b1;
								state_q     <= S_HOLD;
							end else begin
								wy_q    <= wy_q + 16'd1;
								wm_q    <= MONTH_JAN;
								ret_q   <= S_ADD_STEP;
								state_q <= S_LEAP_MUL;
							end
						end else begin
							wm_q <= wm_q + 4'd1;
						end
					end else begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					cur_year_q  <= wy_q;
					cur_month_q <= wm_q;
					cur_day_q   <= wd_q[DAY_W-1:0];
					cur_leap_q  <= wleap_q;
					state_q     <= S_HOLD;
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_HOLD) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_HOLD) && out_free) begin
			out_q.out_year      <= cur_year_q;
			out_q.out_month     <= cur_month_q;
			out_q.out_day       <= cur_day_q;
			out_q.is_later      <= flags_q.later;
			out_q.is_equal      <= flags_q.equal;
			out_q.bad_load      <= flags_q.bad;
			out_q.year_overflow <= flags_q.ovf;
		end
	end

	// Checks
	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_month_q >= MONTH_JAN) && (cur_month_q <= MONTH_DEC))
		else $error("stored month out of range");

	a_day_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_day_q != '0) && (cur_day_q <= month_len(cur_month_q, cur_leap_q)))
		else $error("stored day outside its month");

	a_leap_sync: assert property (@(posedge clk) disable iff (!arst_n)
		cur_leap_q |-> (cur_year_q[1:0] == 2'b00))
		else $error("leap flag out of step with stored year");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.bad_load && out_q.year_overflow))
		else $error("bad load and overflow flagged together");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_HOLD) && out_free) |=> (state_q == S_IDLE) && out_valid_q)
		else $error("result not presented on leaving hold");

endmodule
`default_nettype wire

>>> dv/date_checker.sv
// Date checker: watches both channels, predicts each result and compares it.
`default_nettype none
module date_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              req_ready,
	input  wire cdc_pkg::cdc_req_t req_data,
	input  wire logic              res_valid,
	input  wire logic              res_ready,
	input  wire cdc_pkg::cdc_res_t res_data,
	output int                     fails,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import cdc_pkg::*;

	// Shadow copy of the stored date
	int unsigned cal_year;
	int unsigned cal_month;
	int unsigned cal_day;

	// Results still owed by the block, oldest first
	cdc_res_t expected_dates[$];

	function automatic bit leap(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	// Apply one request to the shadow date and return the result it owes
	function automatic cdc_res_t apply_request(input cdc_req_t r);
		int unsigned y, m, d, len;
		cdc_flags_t f;
		cdc_res_t res;
		f = '0;
		y = cal_year;
		m = cal_month;
		d = cal_day;
		case (r.req_type)
			REQ_LOAD: begin
				if (r.in_month < MONTH_JAN || r.in_month > MONTH_DEC || r.in_year == 0) begin
					f.bad = 1'b1;
				end else begin
					len = month_days(r.in_month, r.in_year);
					y = r.in_year;
					m = r.in_month;
					d = (r.in_day == 0 || r.in_day > len) ? len : r.in_day;
				end
			end
			REQ_INC: begin
				d = d + 1;
				if (d > month_days(m, y)) begin
					d = 1;
					m = m + 1;
					if (m > MONTH_DEC) begin
						m = MONTH_JAN;
						y = y + 1;
					end
				end
				if (y > YEAR_MAX)
					f.ovf = 1'b1;
			end
			REQ_DEC: begin
				if (d > 1) begin
					d = d - 1;
				end else if (m > MONTH_JAN) begin
					m = m - 1;
					d = month_days(m, y);
				end else if (y > 1) begin
					y = y - 1;
					m = MONTH_DEC;
					d = DAY_LAST_DEC;
				end else begin
					f.ovf = 1'b1;
				end
			end
			REQ_ADD: begin
				// walk whole months until the day fits
				d = d + r.day_count;
				len = month_days(m, y);
				while (len != 0 && d > len && !f.ovf) begin
					d = d - len;
					m = m + 1;
					if (m > MONTH_DEC) begin
						m = MONTH_JAN;
						y = y + 1;
						if (y > YEAR_MAX)
							f.ovf = 1'b1;
					end
					len = month_days(m, y);
				end
			end
			REQ_COMPARE: begin
				// order by year, then month, then day; operand taken as is
				if (cal_year != r.in_year)
					f.later = cal_year > r.in_year;
				else if (cal_month != r.in_month)
					f.later = cal_month > r.in_month;
				else if (cal_day != r.in_day)
					f.later = cal_day > r.in_day;
				else
					f.equal = 1'b1;
			end
			default: ;
		endcase
		if (!f.ovf) begin
			cal_year  = y;
			cal_month = m;
			cal_day   = d;
		end
		res.out_year      = cal_year[YEAR_W-1:0];
		res.out_month     = cal_month[MONTH_W-1:0];
		res.out_day       = cal_day[DAY_W-1:0];
		res.is_later      = f.later;
		res.is_equal      = f.equal;
		res.bad_load      = f.bad;
		res.year_overflow = f.ovf;
		return res;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			fails++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Sample both channels at the rising edge
	always @(posedge clk) begin
		cdc_res_t want;
		if (!arst_n) begin
			cal_year  = 1;
			cal_month = 1;
			cal_day   = 1;
			expected_dates.delete();
			fails   = 0;
			pending = 0;
		end else begin
			if (res_valid && res_ready) begin
				if (expected_dates.size() == 0) begin
					fails++;
					$display("%0t: result with no request waiting, expected none, got %0d-%0d-%0d",
						$time, res_data.out_year, res_data.out_month, res_data.out_day);
				end else begin
					want = expected_dates.pop_front();
					check_field("out_year", want.out_year, res_data.out_year);
					check_field("out_month", want.out_month, res_data.out_month);
					check_field("out_day", want.out_day, res_data.out_day);
					check_field("is_later", want.is_later, res_data.is_later);
					check_field("is_equal", want.is_equal, res_data.is_equal);
					check_field("bad_load", want.bad_load, res_data.bad_load);
					check_field("year_overflow", want.year_overflow, res_data.year_overflow);
				end
			end
			if (req_valid && req_ready)
				expected_dates.push_back(apply_request(req_data));
			pending = expected_dates.size();
		end
	end

endmodule
`default_nettype wire

>>> dv/tb.sv
// Testbench top: drives date requests and result back-pressure, gives the verdict.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cdc_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 5_000_000;
	localparam int unsigned SETTLE_CYCLES = 2600;
	localparam int unsigned RANDOM_ITEMS = 400;

	// Codes the block ignores
	localparam logic [REQ_W-1:0] REQ_UNUSED_5 = 3'd5;
	localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fails;
	int pending;
	bit calm = 1'b0;
	int unsigned cycles = 0;

	cdc_chan_if #(.payload_t(cdc_req_t)) req_ch ();
	cdc_chan_if #(.payload_t(cdc_res_t)) res_ch ();

	calendar_date_counter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	date_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_ch.valid),
		.req_ready (req_ch.ready),
		.req_data  (req_ch.data),
		.res_valid (res_ch.valid),
		.res_ready (res_ch.ready),
		.res_data  (res_ch.data),
		.fails     (fails),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("calendar_date_counter: mismatch");
			$finish;
		end
	end

	// Result back-pressure, off during the calm stretch
	always @(negedge clk) begin
		res_ch.ready <= calm || ($urandom_range(99) >= 25);
	end

	function automatic cdc_req_t noise_item();
		cdc_req_t r;
		r.req_type  = REQ_W'($urandom_range(7));
		r.in_year   = YEAR_W'($urandom_range(65535));
		r.in_month  = MONTH_W'($urandom_range(15));
		r.in_day    = DAY_W'($urandom_range(31));
		r.day_count = COUNT_W'($urandom_range(65535));
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic push_request(input cdc_req_t r);
		while (!calm && $urandom_range(99) < 25) begin
			req_ch.valid <= 1'b0;
			req_ch.data  <= noise_item();
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	task automatic send(input logic [REQ_W-1:0] op, input int unsigned y,
		input int unsigned m, input int unsigned d, input int unsigned c);
		cdc_req_t r;
		r.req_type  = op;
		r.in_year   = y[YEAR_W-1:0];
		r.in_month  = m[MONTH_W-1:0];
		r.in_day    = d[DAY_W-1:0];
		r.day_count = c[COUNT_W-1:0];
		push_request(r);
	endtask

	// Hold the sender off until every owed result is back
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	function automatic int unsigned pick_year();
		case ($urandom_range(9))
			0:       return $urandom_range(1, 3);
			1:       return $urandom_range(65532, 65535);
			2:       return $urandom_range(1, 65535);
			3:       return $urandom_range(1, 655) * 100;
			default: return $urandom_range(1890, 2110);
		endcase
	endfunction

	function automatic int unsigned pick_count();
		case ($urandom_range(49))
			0:          return $urandom_range(65535);
			1, 2, 3, 4: return $urandom_range(400, 4000);
			default:    return $urandom_range(60);
		endcase
	endfunction

	initial begin
		int unsigned k, y, m, d;
		int unsigned last_y, last_m;
		last_y = 2000;
		last_m = 1;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset date, refused loads, day clamp, leap rules, edges of the range
		send(REQ_COMPARE, 1, 1, 1, 0);
		send(REQ_DEC, 0, 0, 0, 0);
		send(REQ_LOAD, 2024, 0, 5, 0);
		send(REQ_LOAD, 2024, 13, 5, 0);
		send(REQ_LOAD, 0, 6, 5, 0);
		send(REQ_LOAD, 2024, 2, 0, 0);
		send(REQ_INC, 0, 0, 0, 0);
		send(REQ_DEC, 0, 0, 0, 0);
		send(REQ_LOAD, 1900, 2, 31, 0);
		send(REQ_LOAD, 2000, 2, 30, 0);
		send(REQ_LOAD, 2001, 1, 1, 0);
		send(REQ_DEC, 0, 0, 0, 0);
		send(REQ_ADD, 0, 0, 0, 0);
		send(REQ_ADD, 0, 0, 0, 65535);
		send(REQ_LOAD, 65535, 12, 31, 0);
		send(REQ_INC, 0, 0, 0, 0);
		send(REQ_ADD, 0, 0, 0, 1);
		send(REQ_ADD, 0, 0, 0, 65535);
		send(REQ_COMPARE, 65535, 12, 31, 0);
		send(REQ_COMPARE, 65535, 15, 0, 0);
		send(REQ_COMPARE, 0, 0, 0, 0);
		send(REQ_UNUSED_5, 65535, 15, 31, 65535);
		send(REQ_UNUSED_6, 0, 0, 0, 0);
		send(REQ_UNUSED_7, 1234, 7, 17, 321);
		drain();

		// Random: mostly well-formed requests around loaded dates
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm <= (n >= 150 && n < 250);
			if (n == 300)
				drain();
			k = $urandom_range(99);
			if (k < 18) begin
				y = ($urandom_range(19) == 0) ? 0 : pick_year();
				m = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 12);
				d = $urandom_range(31);
				send(REQ_LOAD, y, m, d, 0);
				if (y != 0 && m >= 1 && m <= 12) begin
					last_y = y;
					last_m = m;
				end
				// echo the requested date back to hit the equal case
				if (d >= 1 && d <= 28 && $urandom_range(2) == 0)
					send(REQ_COMPARE, y, m, d, 0);
			end else if (k < 36) begin
				send(REQ_INC, 0, 0, 0, 0);
			end else if (k < 54) begin
				send(REQ_DEC, 0, 0, 0, 0);
			end else if (k < 72) begin
				send(REQ_ADD, 0, 0, 0, pick_count());
			end else if (k < 92) begin
				y = last_y + $urandom_range(2) - 1;
				m = ($urandom_range(3) == 0) ? $urandom_range(15) : last_m;
				send(REQ_COMPARE, y, m, $urandom_range(31), 0);
			end else begin
				push_request(noise_item());
			end
		end
		calm <= 1'b0;
		req_ch.valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fails == 0)
			$display("calendar_date_counter: match");
		else
			$display("calendar_date_counter: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
